// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on i_clk and held off while reset is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/smwfh_pkg.sv =====
// ---------------------------------------------------------------------------
// smwfh_pkg
// Constants and sequencer types for the word-fold identifier hash.
// ---------------------------------------------------------------------------
package smwfh_pkg;

    localparam logic [63:0] HASH_DOMAIN = 64'h54575A4D46494C45;
    localparam logic [63:0] MIX_ADD     = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL1    = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL2    = 64'h94D049BB133111EB;

    localparam int unsigned WORD_BYTES = 8;

    // Partial product phases of one 64-bit truncated multiply.
    localparam logic [1:0] PH_LL = 2'd0;   // x[31:0]  * c[31:0]
    localparam logic [1:0] PH_LH = 2'd1;   // x[31:0]  * c[63:32]
    localparam logic [1:0] PH_HL = 2'd2;   // x[63:32] * c[31:0]

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_MUL,
        ST_XOR,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        JOB_SEED,
        JOB_WORD,
        JOB_TAIL,
        JOB_LOW
    } t_job;

endpackage

// ===== hw/rtl/splitmix_word_fold_hash.sv =====
// ---------------------------------------------------------------------------
// splitmix_word_fold_hash
// 128-bit identifier hash over a little-endian 64-bit word stream.
// ---------------------------------------------------------------------------
// Each message is a run of 64-bit words ending in an item with tlast set.
// The first item of a message seeds the running hash with
// mix(DOMAIN ^ file_size), where mix is the SplitMix64 finalizer; every item
// is then masked to its byte_count, XORed in and mixed. On the last item a
// full word is followed by one more mix of a zero tail, and one result item
// carries id_high = hash and id_low = mix(hash ^ DOMAIN), with id_low forced
// to 1 if both halves would be zero. All mixing runs on one shared 32x32
// multiplier: each 64-bit multiply is built from three partial products, so
// one mix steps through add/shift, 3 multiply, shift, 3 multiply, shift.
// Input is ready only while idle, so a word waits until the previous item's
// mixes are done; the first item of a message adds a seed mix, and the last
// adds the id_low mix plus, for a full word, a zero-tail mix. Write file_size
// only between messages; it is sampled when a message starts. A finished result
// waits in the output register while the next message's words are taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module splitmix_word_fold_hash (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration: file_size
    input  logic         i_cfg_we,
    input  logic [63:0]  i_cfg_wdata,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,   // [63:0] data_word, [67:64] byte_count, rest zero
    input  logic         s_axis_tlast,   // last_word
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // [63:0] id_high, [127:64] id_low
);

    // Sequencer and job tracking
    smwfh_pkg::t_state r_state, n_state;
    smwfh_pkg::t_job   r_job,   n_job;
    logic [1:0]        r_ph,    n_ph;
    logic              r_rnd,   n_rnd;

    // Message state
    logic              r_in_msg, n_in_msg;
    logic              r_last,   n_last;
    logic              r_full,   n_full;
    logic [63:0]       r_fsize;

    // Datapath
    logic [63:0]       r_word, n_word;
    logic [63:0]       r_v,    n_v;
    logic [63:0]       r_prod, n_prod;
    logic [63:0]       r_hash, n_hash;

    // Output slot
    logic              r_out_valid, n_out_valid;
    logic [63:0]       r_out_hi,    n_out_hi;
    logic [63:0]       r_out_lo,    n_out_lo;

    // Combinational helpers
    logic              w_accept;
    logic              w_slot_free;
    logic [3:0]        w_cnt;
    logic [63:0]       w_masked;
    logic [63:0]       w_pre;
    logic [63:0]       w_res;
    logic [63:0]       w_const;
    logic [31:0]       w_mul_a;
    logic [31:0]       w_mul_b;
    logic [63:0]       w_pp;

    assign s_axis_tready = (r_state == smwfh_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_lo, r_out_hi};

    // Saturate the byte count at a full word, then keep only the valid bytes.
    assign w_cnt = (s_axis_tdata[67:64] > 4'(smwfh_pkg::WORD_BYTES))
                 ? 4'(smwfh_pkg::WORD_BYTES) : s_axis_tdata[67:64];

    always_comb begin
        for (int j = 0; j < smwfh_pkg::WORD_BYTES; j++) begin
            w_masked[8*j +: 8] = (w_cnt > 4'(j)) ? s_axis_tdata[8*j +: 8] : 8'h00;
        end
    end

    // Mix entry: add the golden-ratio constant, then the first xor-shift.
    always_comb begin
        logic [63:0] sum;
        sum   = r_v + smwfh_pkg::MIX_ADD;
        w_pre = sum ^ (sum >> 30);
    end

    // Mix exit: last xor-shift on the second product.
    assign w_res = r_prod ^ (r_prod >> 31);

    // Shared 32x32 multiplier; the low 64 bits of a 64x64 product need three
    // partial products, the high-by-high one falls off the top.
    assign w_const = r_rnd ? smwfh_pkg::MIX_MUL2 : smwfh_pkg::MIX_MUL1;

    always_comb begin
        unique case (r_ph)
            smwfh_pkg::PH_LL: begin
                w_mul_a = r_v[31:0];
                w_mul_b = w_const[31:0];
            end
            smwfh_pkg::PH_LH: begin
                w_mul_a = r_v[31:0];
                w_mul_b = w_const[63:32];
            end
            smwfh_pkg::PH_HL: begin
                w_mul_a = r_v[63:32];
                w_mul_b = w_const[31:0];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_pp = {32'h0, w_mul_a} * {32'h0, w_mul_b};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smwfh_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = smwfh_pkg::ST_PRE;
                end
            end
            smwfh_pkg::ST_PRE: begin
                n_state = smwfh_pkg::ST_MUL;
            end
            smwfh_pkg::ST_MUL: begin
                if (r_ph == smwfh_pkg::PH_HL) begin
                    n_state = r_rnd ? smwfh_pkg::ST_FIN : smwfh_pkg::ST_XOR;
                end
            end
            smwfh_pkg::ST_XOR: begin
                n_state = smwfh_pkg::ST_MUL;
            end
            smwfh_pkg::ST_FIN: begin
                unique case (r_job)
                    smwfh_pkg::JOB_SEED,
                    smwfh_pkg::JOB_TAIL: begin
                        n_state = smwfh_pkg::ST_PRE;
                    end
                    smwfh_pkg::JOB_WORD: begin
                        n_state = r_last ? smwfh_pkg::ST_PRE : smwfh_pkg::ST_IDLE;
                    end
                    smwfh_pkg::JOB_LOW: begin
                        if (w_slot_free) begin
                            n_state = smwfh_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        n_state = smwfh_pkg::ST_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = smwfh_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and job control
    always_comb begin
        n_job       = r_job;
        n_ph        = r_ph;
        n_rnd       = r_rnd;
        n_in_msg    = r_in_msg;
        n_last      = r_last;
        n_full      = r_full;
        n_word      = r_word;
        n_v         = r_v;
        n_prod      = r_prod;
        n_hash      = r_hash;
        n_out_hi    = r_out_hi;
        n_out_lo    = r_out_lo;
        n_out_valid = r_out_valid && !m_axis_tready;

        unique case (r_state)
            smwfh_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_word   = w_masked;
                    n_last   = s_axis_tlast;
                    n_full   = (w_cnt == 4'(smwfh_pkg::WORD_BYTES));
                    n_in_msg = 1'b1;
                    // A new message seeds first; otherwise fold the word now.
                    if (r_in_msg) begin
                        n_v   = r_hash ^ w_masked;
                        n_job = smwfh_pkg::JOB_WORD;
                    end else begin
                        n_v   = smwfh_pkg::HASH_DOMAIN ^ r_fsize;
                        n_job = smwfh_pkg::JOB_SEED;
                    end
                end
            end
            smwfh_pkg::ST_PRE: begin
                n_v   = w_pre;
                n_rnd = 1'b0;
                n_ph  = smwfh_pkg::PH_LL;
            end
            smwfh_pkg::ST_MUL: begin
                if (r_ph == smwfh_pkg::PH_LL) begin
                    n_prod = w_pp;
                end else begin
                    n_prod[63:32] = r_prod[63:32] + w_pp[31:0];
                end
                n_ph = (r_ph == smwfh_pkg::PH_HL) ? smwfh_pkg::PH_LL : r_ph + 2'd1;
            end
            smwfh_pkg::ST_XOR: begin
                n_v   = r_prod ^ (r_prod >> 27);
                n_rnd = 1'b1;
            end
            smwfh_pkg::ST_FIN: begin
                unique case (r_job)
                    smwfh_pkg::JOB_SEED: begin
                        n_hash = w_res;
                        n_v    = w_res ^ r_word;
                        n_job  = smwfh_pkg::JOB_WORD;
                    end
                    smwfh_pkg::JOB_WORD: begin
                        n_hash = w_res;
                        // A full last word gets an extra zero-tail mix.
                        if (r_full) begin
                            n_v   = w_res;
                            n_job = smwfh_pkg::JOB_TAIL;
                        end else begin
                            n_v   = w_res ^ smwfh_pkg::HASH_DOMAIN;
                            n_job = smwfh_pkg::JOB_LOW;
                        end
                    end
                    smwfh_pkg::JOB_TAIL: begin
                        n_hash = w_res;
                        n_v    = w_res ^ smwfh_pkg::HASH_DOMAIN;
                        n_job  = smwfh_pkg::JOB_LOW;
                    end
                    smwfh_pkg::JOB_LOW: begin
                        // Hold here until the output slot frees up.
                        if (w_slot_free) begin
                            n_out_hi    = r_hash;
                            n_out_lo    = (r_hash == 64'h0 && w_res == 64'h0) ? 64'h1 : w_res;
                            n_out_valid = 1'b1;
                            n_in_msg    = 1'b0;
                        end
                    end
                    default: begin
                        n_in_msg = 1'b0;
                    end
                endcase
            end
            default: begin
                n_ph = smwfh_pkg::PH_LL;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smwfh_pkg::ST_IDLE;
            r_job       <= smwfh_pkg::JOB_SEED;
            r_ph        <= smwfh_pkg::PH_LL;
            r_rnd       <= 1'b0;
            r_in_msg    <= 1'b0;
            r_out_valid <= 1'b0;
            r_fsize     <= 64'h0;
            r_hash      <= 64'h0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_ph        <= n_ph;
            r_rnd       <= n_rnd;
            r_in_msg    <= n_in_msg;
            r_out_valid <= n_out_valid;
            r_hash      <= n_hash;
            if (i_cfg_we) begin
                r_fsize <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_last   <= n_last;
        r_full   <= n_full;
        r_word   <= n_word;
        r_v      <= n_v;
        r_prod   <= n_prod;
        r_out_hi <= n_out_hi;
        r_out_lo <= n_out_lo;
    end

    // Assertions
    `ASSERT_IMPLY(a_no_zero_id, m_axis_tvalid, m_axis_tdata != 128'h0,
        "result identifier is all zero")
    `ASSERT_NEXT(a_accept_starts_mix, w_accept, r_state == smwfh_pkg::ST_PRE,
        "accepted item did not start a mix")
    `ASSERT_ALWAYS(a_phase_range, r_ph != 2'd3, "multiply phase out of range")
    `ASSERT_NEXT(a_stall_holds_result,
        r_state == smwfh_pkg::ST_FIN && r_job == smwfh_pkg::JOB_LOW && !w_slot_free,
        r_state == smwfh_pkg::ST_FIN && m_axis_tvalid,
        "final mix left while output slot was busy")
    `ASSERT_IMPLY(a_busy_in_msg, r_state != smwfh_pkg::ST_IDLE, r_in_msg,
        "sequencer busy outside a message")

endmodule
